### rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the ring buffer deque: word layouts,
// operation and status codes, controller states and control bundles.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Capacity and data size (capacity must be a power of two)
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the channel words
  localparam int OP_W  = 3;
  localparam int POS_W = 6;
  localparam int LEN_W = 7;
  localparam int ST_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_RESIZE     = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_RANGE = 3'd3,
    ST_OVER  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_FILL = 2'd3
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [POS_W-1:0]       position;
    logic signed [31:0]     data_in;
    logic [LEN_W-1:0]       target_length;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]     data_out;
    logic [LEN_W-1:0]       length;
    status_t                status;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted input word
    logic rd_issue;  // start the store read for a pop or read
    logic fill;      // write one zero entry and grow the count
    logic commit;    // apply the update and load the result word
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_read; // operation succeeds and returns a stored value
    logic grow;       // resize still has entries to clear
    logic out_free;   // result register can take a new word
  } dp_sts_t;

endpackage

### rtl/rbd_ram.sv
// ----------------------------------------------------------------------------
// rbd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl
// Sequencer for the deque: accept a word, then execute it, with a read
// wait for pops and reads and a zero fill loop for growing resizes.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rbd_pkg::dp_sts_t sts,
  output rbd_pkg::dp_cmd_t cmd
);

  rbd_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rbd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = rbd_pkg::S_EXEC;
        end
      end
      rbd_pkg::S_EXEC: begin
        if (sts.grow) begin
          state_nxt = rbd_pkg::S_FILL;
        end else if (sts.needs_read) begin
          state_nxt = rbd_pkg::S_READ;
        end else if (sts.out_free) begin
          state_nxt = rbd_pkg::S_IDLE;
        end
      end
      rbd_pkg::S_READ: begin
        if (sts.out_free) begin
          state_nxt = rbd_pkg::S_IDLE;
        end
      end
      rbd_pkg::S_FILL: begin
        if (!sts.grow) begin
          state_nxt = rbd_pkg::S_EXEC;
        end
      end
      default: state_nxt = rbd_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.fill     = 1'b0;
    cmd.commit   = 1'b0;
    case (state_r)
      rbd_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      rbd_pkg::S_EXEC: begin
        cmd.rd_issue = sts.needs_read && !sts.grow;
        cmd.commit   = !sts.grow && !sts.needs_read && sts.out_free;
      end
      rbd_pkg::S_READ: begin
        cmd.commit = sts.out_free;
      end
      rbd_pkg::S_FILL: begin
        cmd.fill = sts.grow;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/rbd_dp.sv
// ----------------------------------------------------------------------------
// rbd_dp
// Deque datapath: held input word, front pointer, element count, ring
// store, operation decode and the registered result word.
// ----------------------------------------------------------------------------
module rbd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rbd_pkg::in_word_t  in_data,
  input  rbd_pkg::dp_cmd_t   cmd,
  output rbd_pkg::dp_sts_t   sts,
  output logic               out_valid,
  input  logic               out_ready,
  output rbd_pkg::out_word_t out_data
);

  rbd_pkg::in_word_t           item_r;
  logic [rbd_pkg::PTR_W-1:0]   front_r, front_nxt;
  logic [rbd_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        out_valid_r;
  rbd_pkg::out_word_t          out_r;

  logic [rbd_pkg::CNT_W-1:0]   pos_ext;
  logic [rbd_pkg::CNT_W-1:0]   tgt;
  logic                        full, empty, pos_ok, over;
  logic [rbd_pkg::PTR_W-1:0]   back_slot, last_slot, pos_slot, pre_front;
  rbd_pkg::status_t            status;
  logic                        wr_op;
  logic [rbd_pkg::PTR_W-1:0]   wr_addr;
  logic [rbd_pkg::PTR_W-1:0]   rd_addr;
  logic                        ram_we;
  logic [rbd_pkg::PTR_W-1:0]   ram_waddr;
  logic [rbd_pkg::DATA_WIDTH-1:0] ram_wdata;
  logic [rbd_pkg::DATA_WIDTH-1:0] ram_rdata;

  // Hold the accepted word for the whole operation
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // Slot arithmetic wraps at the power-of-two capacity
  assign pos_ext   = rbd_pkg::CNT_W'(item_r.position);
  assign tgt       = rbd_pkg::CNT_W'(item_r.target_length);
  assign full      = (count_r == rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
  assign empty     = (count_r == '0);
  assign pos_ok    = (pos_ext < count_r);
  assign over      = (tgt > rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
  assign back_slot = front_r + count_r[rbd_pkg::PTR_W-1:0];
  assign last_slot = back_slot - rbd_pkg::PTR_W'(1);
  assign pos_slot  = front_r + pos_ext[rbd_pkg::PTR_W-1:0];
  assign pre_front = front_r - rbd_pkg::PTR_W'(1);

  // Decode the operation against the current pointers
  always_comb begin
    status           = rbd_pkg::ST_OK;
    wr_op            = 1'b0;
    wr_addr          = back_slot;
    rd_addr          = front_r;
    sts.needs_read   = 1'b0;
    sts.grow         = 1'b0;
    sts.out_free     = !out_valid_r || out_ready;
    front_nxt        = front_r;
    count_nxt        = count_r;
    case (rbd_pkg::op_t'(item_r.operation))
      rbd_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = rbd_pkg::ST_FULL;
        end else begin
          wr_op     = 1'b1;
          count_nxt = count_r + rbd_pkg::CNT_W'(1);
        end
      end
      rbd_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = rbd_pkg::ST_FULL;
        end else begin
          wr_op     = 1'b1;
          wr_addr   = pre_front;
          front_nxt = pre_front;
          count_nxt = count_r + rbd_pkg::CNT_W'(1);
        end
      end
      rbd_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = rbd_pkg::ST_EMPTY;
        end else begin
          sts.needs_read = 1'b1;
          rd_addr        = last_slot;
          count_nxt      = count_r - rbd_pkg::CNT_W'(1);
        end
      end
      rbd_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = rbd_pkg::ST_EMPTY;
        end else begin
          sts.needs_read = 1'b1;
          front_nxt      = front_r + rbd_pkg::PTR_W'(1);
          count_nxt      = count_r - rbd_pkg::CNT_W'(1);
        end
      end
      rbd_pkg::OP_READ: begin
        if (!pos_ok) begin
          status = rbd_pkg::ST_RANGE;
        end else begin
          sts.needs_read = 1'b1;
          rd_addr        = pos_slot;
        end
      end
      rbd_pkg::OP_WRITE: begin
        if (!pos_ok) begin
          status = rbd_pkg::ST_RANGE;
        end else begin
          wr_op   = 1'b1;
          wr_addr = pos_slot;
        end
      end
      rbd_pkg::OP_RESIZE: begin
        if (over) begin
          status = rbd_pkg::ST_OVER;
        end else begin
          sts.grow  = (tgt > count_r);
          count_nxt = tgt;
        end
      end
      default: begin
        status = rbd_pkg::ST_OK;
      end
    endcase
  end

  // Store write: committed push or write, or one zero entry of a fill
  assign ram_we    = (cmd.commit && wr_op) || cmd.fill;
  assign ram_waddr = cmd.fill ? back_slot : wr_addr;
  assign ram_wdata = cmd.fill ? '0 : rbd_pkg::DATA_WIDTH'(item_r.data_in);

  rbd_ram #(
    .WIDTH (rbd_pkg::DATA_WIDTH),
    .DEPTH (rbd_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Advance pointers on commit, grow the count one entry per fill cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (cmd.fill) begin
      count_r <= count_r + rbd_pkg::CNT_W'(1);
    end else if (cmd.commit) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.data_out <= sts.needs_read ? signed'(32'(ram_rdata)) : '0;
      out_r.length   <= rbd_pkg::LEN_W'(count_nxt);
      out_r.status   <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/ring_buffer_deque_unit.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque_unit
// Fixed-capacity double-ended queue in a ring store with front pointer and
// element count; push, pop, indexed read/write and resize with zero fill.
//
//   channel  ports                        word
//   -------  ---------------------------  -------------------------------
//   input    in_valid in_ready in_data    operation position data_in
//                                         target_length
//   result   out_valid out_ready out_data data_out length status
//
// One word at a time. Pop and read wait for the registered read port of the
// ring store before the result is loaded; push, write, resize without growth
// and any failed operation load it straight from execute. A growing resize
// first runs the zero fill, which writes one entry per cycle through the single
// write port, then returns to execute to load its result.
// The next word is accepted the cycle after the result is loaded, even while
// that result waits for out_ready.
// Reset clears the pointers, the count and the result valid flag; the store is not cleared.
// ----------------------------------------------------------------------------
module ring_buffer_deque_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rbd_pkg::out_word_t out_data
);

  rbd_pkg::dp_cmd_t cmd;
  rbd_pkg::dp_sts_t sts;

  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sim/ring_buffer_deque_unit_tb.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque_unit_tb
// Self-checking bench for the ring buffer deque. A driver feeds words from a
// backlog, a predictor holds its own copy of the ring, front pointer and
// count, and a monitor compares each result word field by field. The run
// steps through four handshake phases: no idling, sender gaps, receiver
// stalls, and both together.
// ----------------------------------------------------------------------------
module ring_buffer_deque_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rbd_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_WORDS = 1350;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    rbd_pkg::in_word_t w;
    int                ph;
  } queued_word_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  rbd_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rbd_pkg::out_word_t out_data;

  queued_word_t       word_backlog[$];
  rbd_pkg::out_word_t awaited_results[$];
  int                 cur_phase = 0;
  int                 words_sent = 0;
  int                 words_checked = 0;
  int                 failures = 0;
  int                 status_hits[5] = '{default: 0};

  // Shadow deque used by the predictor
  logic signed [31:0]        deque_ring[rbd_pkg::DEPTH];
  logic [rbd_pkg::PTR_W-1:0] deque_front = '0;
  logic [rbd_pkg::LEN_W-1:0] deque_count = '0;

  // Length seen by the stimulus plan, used to aim positions and resizes
  int plan_len = 0;

  ring_buffer_deque_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Apply one word to the shadow deque and return the result it must produce
  function automatic rbd_pkg::out_word_t deque_step(rbd_pkg::in_word_t w);
    rbd_pkg::out_word_t        r;
    logic [rbd_pkg::PTR_W-1:0] s;
    int                        i;
    r.data_out = '0;
    r.status   = rbd_pkg::ST_OK;
    case (w.operation)
      rbd_pkg::OP_PUSH_BACK: begin
        if (deque_count == rbd_pkg::DEPTH) begin
          r.status = rbd_pkg::ST_FULL;
        end else begin
          s = deque_front + deque_count[rbd_pkg::PTR_W-1:0];
          deque_ring[s] = w.data_in;
          deque_count++;
        end
      end
      rbd_pkg::OP_PUSH_FRONT: begin
        if (deque_count == rbd_pkg::DEPTH) begin
          r.status = rbd_pkg::ST_FULL;
        end else begin
          deque_front = deque_front - 1'b1;
          deque_ring[deque_front] = w.data_in;
          deque_count++;
        end
      end
      rbd_pkg::OP_POP_BACK: begin
        if (deque_count == 0) begin
          r.status = rbd_pkg::ST_EMPTY;
        end else begin
          s = deque_front + deque_count[rbd_pkg::PTR_W-1:0] - 1'b1;
          r.data_out = deque_ring[s];
          deque_count--;
        end
      end
      rbd_pkg::OP_POP_FRONT: begin
        if (deque_count == 0) begin
          r.status = rbd_pkg::ST_EMPTY;
        end else begin
          r.data_out = deque_ring[deque_front];
          deque_front++;
          deque_count--;
        end
      end
      rbd_pkg::OP_READ: begin
        if (w.position >= deque_count) begin
          r.status = rbd_pkg::ST_RANGE;
        end else begin
          s = deque_front + w.position;
          r.data_out = deque_ring[s];
        end
      end
      rbd_pkg::OP_WRITE: begin
        if (w.position >= deque_count) begin
          r.status = rbd_pkg::ST_RANGE;
        end else begin
          s = deque_front + w.position;
          deque_ring[s] = w.data_in;
        end
      end
      rbd_pkg::OP_RESIZE: begin
        if (w.target_length > rbd_pkg::DEPTH) begin
          r.status = rbd_pkg::ST_OVER;
        end else begin
          // zero the newly exposed tail, then take the new length
          for (i = deque_count; i < w.target_length; i++) begin
            s = deque_front + i[rbd_pkg::PTR_W-1:0];
            deque_ring[s] = '0;
          end
          deque_count = w.target_length;
        end
      end
      default: begin
      end
    endcase
    r.length = deque_count;
    return r;
  endfunction

  // Queue one word for the driver and track the length it leaves behind
  task automatic add_word(logic [rbd_pkg::OP_W-1:0] op, logic [rbd_pkg::POS_W-1:0] pos,
                          logic [31:0] data, logic [rbd_pkg::LEN_W-1:0] tgt, int ph);
    queued_word_t q;
    q.w.operation     = op;
    q.w.position      = pos;
    q.w.data_in       = data;
    q.w.target_length = tgt;
    q.ph              = ph;
    word_backlog.insert(word_backlog.size(), q);
    case (op)
      rbd_pkg::OP_PUSH_BACK, rbd_pkg::OP_PUSH_FRONT:
        if (plan_len < rbd_pkg::DEPTH) plan_len++;
      rbd_pkg::OP_POP_BACK, rbd_pkg::OP_POP_FRONT:
        if (plan_len > 0) plan_len--;
      rbd_pkg::OP_RESIZE:
        if (tgt <= rbd_pkg::DEPTH) plan_len = tgt;
      default: begin
      end
    endcase
  endtask

  task automatic note_failure(string msg);
    if (failures < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    failures++;
  endtask

  // Driver: hold the word until accepted, then predict and offer the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.insert(awaited_results.size(), deque_step(in_data));
        word_backlog.delete(0);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (word_backlog.size() != 0 &&
            !(word_backlog[0].ph == 1 && $urandom_range(99) < 57) &&
            !(word_backlog[0].ph == 3 && $urandom_range(99) < 26)) begin
          in_valid  <= 1'b1;
          in_data   <= word_backlog[0].w;
          cur_phase <= word_backlog[0].ph;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    rbd_pkg::out_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("unexpected result word data %0d length %0d status %0d",
                                 out_data.data_out, out_data.length, out_data.status));
        end else begin
          exp_w = awaited_results[0];
          awaited_results.delete(0);
          words_checked++;
          if (exp_w.status <= rbd_pkg::ST_OVER) status_hits[exp_w.status]++;
          if (out_data.data_out !== exp_w.data_out || out_data.length !== exp_w.length ||
              out_data.status !== exp_w.status) begin
            note_failure($sformatf(
              "result %0d: expected data %0d length %0d status %0d, got %0d %0d %0d",
              words_checked, exp_w.data_out, exp_w.length, exp_w.status,
              out_data.data_out, out_data.length, out_data.status));
          end
        end
      end
      if (cur_phase == 2) begin
        out_ready <= ($urandom_range(99) >= 57);
      end else if (cur_phase == 3) begin
        out_ready <= ($urandom_range(99) >= 26);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [rbd_pkg::OP_W-1:0]  op;
    logic [rbd_pkg::POS_W-1:0] pos;
    logic [31:0]               data;
    logic [rbd_pkg::LEN_W-1:0] tgt;
    int                        ph;
    int                        r;
    int                        push_w;
    int                        pop_w;

    // empty deque: pops, out-of-range access and the unused code
    add_word(rbd_pkg::OP_POP_BACK,   6'd0,  32'h0,        7'd0, 0);
    add_word(rbd_pkg::OP_POP_FRONT,  6'd63, 32'hFFFFFFFF, 7'd127, 0);
    add_word(rbd_pkg::OP_READ,       6'd0,  32'h0,        7'd0, 0);
    add_word(rbd_pkg::OP_WRITE,      6'd63, 32'h12345678, 7'd0, 0);
    add_word(OP_UNUSED,              6'd63, 32'hFFFFFFFF, 7'd127, 0);
    // push at both ends with extreme values, front pointer wraps
    add_word(rbd_pkg::OP_PUSH_BACK,  6'd0,  32'h7FFFFFFF, 7'd0, 0);
    add_word(rbd_pkg::OP_PUSH_FRONT, 6'd0,  32'h80000000, 7'd0, 0);
    add_word(rbd_pkg::OP_READ,       6'd0,  32'h0,        7'd0, 0);
    add_word(rbd_pkg::OP_READ,       6'd1,  32'h0,        7'd0, 0);
    add_word(rbd_pkg::OP_WRITE,      6'd1,  32'hFFFFFFFF, 7'd0, 0);
    add_word(rbd_pkg::OP_READ,       6'd1,  32'h0,        7'd0, 0);
    add_word(rbd_pkg::OP_READ,       6'd2,  32'h0,        7'd0, 0);
    // grow to capacity with zero fill, then hit full and over capacity
    add_word(rbd_pkg::OP_RESIZE,     6'd0,  32'h0,        7'd64, 0);
    add_word(rbd_pkg::OP_PUSH_BACK,  6'd0,  32'h1,        7'd0, 0);
    add_word(rbd_pkg::OP_PUSH_FRONT, 6'd0,  32'h2,        7'd0, 0);
    add_word(rbd_pkg::OP_READ,       6'd63, 32'h0,        7'd0, 0);
    add_word(rbd_pkg::OP_WRITE,      6'd63, 32'h80000000, 7'd0, 0);
    add_word(rbd_pkg::OP_RESIZE,     6'd0,  32'h0,        7'd65, 0);
    add_word(rbd_pkg::OP_RESIZE,     6'd0,  32'h0,        7'd127, 0);
    add_word(rbd_pkg::OP_POP_BACK,   6'd0,  32'h0,        7'd0, 0);
    // shrink to nothing, regrow a little, pop from both ends
    add_word(rbd_pkg::OP_RESIZE,     6'd0,  32'h0,        7'd0, 0);
    add_word(rbd_pkg::OP_RESIZE,     6'd0,  32'h0,        7'd3, 0);
    add_word(rbd_pkg::OP_READ,       6'd2,  32'h0,        7'd0, 0);
    add_word(rbd_pkg::OP_POP_BACK,   6'd0,  32'h0,        7'd0, 0);
    add_word(rbd_pkg::OP_POP_FRONT,  6'd0,  32'h0,        7'd0, 0);

    // random part: segments lean toward filling, draining or mixing
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      ph   = i * 4 / RANDOM_WORDS;
      pos  = rbd_pkg::POS_W'($urandom);
      data = $urandom;
      tgt  = rbd_pkg::LEN_W'($urandom);
      case ((i / 40) % 3)
        0:       begin push_w = 55; pop_w = 15; end
        1:       begin push_w = 15; pop_w = 55; end
        default: begin push_w = 33; pop_w = 33; end
      endcase
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(3))
          0:       data = 32'h80000000;
          1:       data = 32'h7FFFFFFF;
          2:       data = 32'h0;
          default: data = 32'hFFFFFFFF;
        endcase
      end
      r = $urandom_range(99);
      if (r < push_w) begin
        op = $urandom_range(1) ? rbd_pkg::OP_PUSH_FRONT : rbd_pkg::OP_PUSH_BACK;
      end else if (r < push_w + pop_w) begin
        op = $urandom_range(1) ? rbd_pkg::OP_POP_FRONT : rbd_pkg::OP_POP_BACK;
      end else if (r < push_w + pop_w + 24) begin
        op = $urandom_range(1) ? rbd_pkg::OP_WRITE : rbd_pkg::OP_READ;
        if (plan_len > 0 && $urandom_range(99) < 85) begin
          pos = rbd_pkg::POS_W'($urandom_range(plan_len - 1));
        end
      end else if (r < push_w + pop_w + 29) begin
        op = rbd_pkg::OP_RESIZE;
        r  = $urandom_range(99);
        if (r < 70) begin
          tgt = rbd_pkg::LEN_W'($urandom_range(rbd_pkg::DEPTH));
        end else if (r < 85) begin
          // land near the current length
          r   = plan_len + int'($urandom_range(8)) - 4;
          tgt = (r < 0) ? '0 : rbd_pkg::LEN_W'(r);
          if (tgt > rbd_pkg::DEPTH) tgt = rbd_pkg::LEN_W'(rbd_pkg::DEPTH);
        end else begin
          tgt = rbd_pkg::LEN_W'($urandom_range(127, rbd_pkg::DEPTH + 1));
        end
      end else begin
        op = OP_UNUSED;
      end
      add_word(op, pos, data, tgt, ph);
    end

    // release reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // drain, then allow for a trailing zero fill
    while (word_backlog.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    failures += awaited_results.size();

    $display("sent %0d words, checked %0d results through four handshake phases",
             words_sent, words_checked);
    $display("status seen: ok %0d, full %0d, empty %0d, out of range %0d, over capacity %0d",
             status_hits[rbd_pkg::ST_OK], status_hits[rbd_pkg::ST_FULL],
             status_hits[rbd_pkg::ST_EMPTY], status_hits[rbd_pkg::ST_RANGE],
             status_hits[rbd_pkg::ST_OVER]);
    if (failures == 0) begin
      $display("ring_buffer_deque_unit_tb OK");
    end else begin
      $display("%0d failures", failures);
      $display("ring_buffer_deque_unit_tb NOT OK");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("timeout with %0d words pending, %0d results awaited",
             word_backlog.size(), awaited_results.size());
    $display("ring_buffer_deque_unit_tb NOT OK");
    $finish;
  end

endmodule
